// File: hw/rtl/gkn_pkg.sv
// Package for the greedy keypoint suppression block.
// Holds the request and result types, internal command and state codes and constants.
// Depends on nothing.
package gkn_pkg;

    localparam int DefMaxCandidates = 1024;
    localparam int MaxCellCols = 128;
    localparam int MaxCellRows = 64;
    localparam int CfgDataW = 22;

    localparam logic [0:0] CfgThreshold = 1'd0;
    localparam logic [0:0] CfgRadiusSq = 1'd1;

    localparam logic FuncLoad = 1'b0;
    localparam logic FuncFetch = 1'b1;

    typedef struct packed {
        logic func;
        logic [6:0] cell_x;
        logic [5:0] cell_y;
        logic [5:0] sub_index;
        logic signed [15:0] score;
        logic last;
    } t_in_item;

    typedef struct packed {
        logic found;
        logic [9:0] pix_x;
        logic [8:0] pix_y;
        logic signed [15:0] key_score;
        logic final_key;
        logic overflow;
    } t_out_item;

    typedef enum logic [1:0] {
        CMD_CAND,
        CMD_SKIP,
        CMD_FETCH
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind kind;
        logic last;
        logic signed [15:0] score;
        logic [9:0] x;
        logic [8:0] y;
    } t_cmd;

    typedef struct packed {
        logic supp;
        logic signed [15:0] score;
        logic [9:0] x;
        logic [8:0] y;
    } t_entry;

    typedef enum logic {
        PH_LOAD,
        PH_FETCH
    } t_phase;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_INS_RD,
        BK_INS_EV,
        BK_INS_WR,
        BK_LAST,
        BK_WI_RD,
        BK_WI_EV,
        BK_WJ_RD,
        BK_WJ_EV,
        BK_FS_RD,
        BK_FS_EV,
        BK_FM_RD,
        BK_FM_EV
    } t_bk_state;

endpackage

// File: hw/rtl/gkn_front.sv
// Front part: accepts requests, classifies them and queues commands for the back part.
// Depends on gkn_pkg.
module gkn_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  gkn_pkg::t_in_item   i_in,
    input  logic signed [15:0]  i_threshold,
    output logic                o_q_valid,
    output gkn_pkg::t_cmd       o_q_head,
    input  logic                i_q_pop
);
    import gkn_pkg::*;

    t_cmd r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd cmd;
    logic take;
    logic in_range;

    assign full = (r_cnt == 2'd2);
    assign take = push && !full;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_head = r_q[r_rp];

    always_comb begin
        in_range = (32'(i_in.cell_x) < MaxCellCols) && (32'(i_in.cell_y) < MaxCellRows);
        cmd.last = i_in.last;
        cmd.score = i_in.score;
        cmd.x = {i_in.cell_x, i_in.sub_index[2:0]};
        cmd.y = {i_in.cell_y, i_in.sub_index[5:3]};
        if (i_in.func == FuncFetch) begin
            cmd.kind = CMD_FETCH;
        end else if (in_range && (i_in.score > i_threshold)) begin
            cmd.kind = CMD_CAND;
        end else begin
            cmd.kind = CMD_SKIP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_q[r_wp] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (take) begin
                r_wp <= !r_wp;
            end
            if (i_q_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(take) - 2'(i_q_pop);
        end
    end

endmodule

// File: hw/rtl/gkn_back.sv
// Back part: sorted candidate store, suppression walk, fetch scan and result register.
// Depends on gkn_pkg.
module gkn_back #(
    parameter int MAX_CANDIDATES = gkn_pkg::DefMaxCandidates
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  gkn_pkg::t_cmd       i_q_head,
    output logic                o_q_pop,
    input  logic [21:0]         i_radius_sq,
    output logic                empty,
    input  logic                pop,
    output gkn_pkg::t_out_item  o_out
);
    import gkn_pkg::*;

    localparam int AW = $clog2(MAX_CANDIDATES);
    localparam int CW = $clog2(MAX_CANDIDATES + 1);

    t_entry mem [MAX_CANDIDATES];
    t_entry r_rdata;
    logic mem_we, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    t_entry wdata;

    t_bk_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic [CW-1:0] r_count, n_count, r_rp, n_rp, r_pos, n_pos, r_j, n_j, cnt_eff;
    logic r_dropped, n_dropped;
    t_cmd r_cmd, n_cmd;
    t_entry r_key, n_key;
    logic [9:0] r_rx, n_rx, dx;
    logic [8:0] r_ry, n_ry, dy;
    logic [19:0] sqx;
    logic [17:0] sqy;
    logic [20:0] dist_sq;
    logic r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    assign empty = !r_out_valid;
    assign o_out = r_out;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= wdata;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_comb begin
        dx = (r_rx > r_rdata.x) ? r_rx - r_rdata.x : r_rdata.x - r_rx;
        dy = (r_ry > r_rdata.y) ? r_ry - r_rdata.y : r_rdata.y - r_ry;
        sqx = 20'(dx) * 20'(dx);
        sqy = 18'(dy) * 18'(dy);
        dist_sq = 21'(sqx) + 21'(sqy);
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_count = r_count;
        n_rp = r_rp;
        n_pos = r_pos;
        n_j = r_j;
        n_dropped = r_dropped;
        n_cmd = r_cmd;
        n_key = r_key;
        n_rx = r_rx;
        n_ry = r_ry;
        n_out_valid = r_out_valid && !pop;
        n_out = r_out;
        o_q_pop = 1'b0;
        mem_we = 1'b0;
        rd_en = 1'b0;
        wr_addr = r_pos[AW-1:0];
        rd_addr = r_pos[AW-1:0];
        wdata = r_rdata;
        cnt_eff = r_count;
        case (r_state)
            BK_IDLE: begin
                if (i_q_valid && !(i_q_head.kind == CMD_FETCH && r_out_valid)) begin
                    o_q_pop = 1'b1;
                    n_cmd = i_q_head;
                    if (i_q_head.kind == CMD_FETCH) begin
                        if (r_phase == PH_FETCH) begin
                            n_pos = r_rp;
                            n_state = BK_FS_RD;
                        end else begin
                            n_out_valid = 1'b1;
                            n_out = '0;
                            n_out.overflow = r_dropped;
                        end
                    end else begin
                        if (r_phase == PH_FETCH) begin
                            cnt_eff = '0;
                            n_count = '0;
                            n_rp = '0;
                            n_dropped = 1'b0;
                            n_phase = PH_LOAD;
                        end
                        if (i_q_head.kind == CMD_CAND) begin
                            if (cnt_eff >= CW'(MAX_CANDIDATES)) begin
                                n_dropped = 1'b1;
                                n_state = BK_LAST;
                            end else begin
                                n_pos = cnt_eff;
                                n_state = (cnt_eff != '0) ? BK_INS_RD : BK_INS_WR;
                            end
                        end else begin
                            n_state = BK_LAST;
                        end
                    end
                end
            end
            BK_INS_RD: begin
                rd_en = 1'b1;
                rd_addr = AW'(r_pos - 1'b1);
                n_state = BK_INS_EV;
            end
            BK_INS_EV: begin
                if (r_rdata.score < r_cmd.score) begin
                    mem_we = 1'b1;
                    n_pos = r_pos - 1'b1;
                    n_state = (r_pos == CW'(1)) ? BK_INS_WR : BK_INS_RD;
                end else begin
                    n_state = BK_INS_WR;
                end
            end
            BK_INS_WR: begin
                mem_we = 1'b1;
                wdata = '{supp: 1'b0, score: r_cmd.score, x: r_cmd.x, y: r_cmd.y};
                n_count = r_count + 1'b1;
                n_state = BK_LAST;
            end
            BK_LAST: begin
                if (r_cmd.last) begin
                    n_pos = '0;
                    n_state = BK_WI_RD;
                end else begin
                    n_state = BK_IDLE;
                end
            end
            BK_WI_RD: begin
                if (r_pos >= r_count) begin
                    n_phase = PH_FETCH;
                    n_rp = '0;
                    n_state = BK_IDLE;
                end else begin
                    rd_en = 1'b1;
                    n_state = BK_WI_EV;
                end
            end
            BK_WI_EV: begin
                if (r_rdata.supp) begin
                    n_pos = r_pos + 1'b1;
                    n_state = BK_WI_RD;
                end else begin
                    n_rx = r_rdata.x;
                    n_ry = r_rdata.y;
                    n_j = r_pos + 1'b1;
                    n_state = BK_WJ_RD;
                end
            end
            BK_WJ_RD: begin
                if (r_j >= r_count) begin
                    n_pos = r_pos + 1'b1;
                    n_state = BK_WI_RD;
                end else begin
                    rd_en = 1'b1;
                    rd_addr = r_j[AW-1:0];
                    n_state = BK_WJ_EV;
                end
            end
            BK_WJ_EV: begin
                if (!r_rdata.supp && (22'(dist_sq) < i_radius_sq)) begin
                    mem_we = 1'b1;
                    wr_addr = r_j[AW-1:0];
                    wdata.supp = 1'b1;
                end
                n_j = r_j + 1'b1;
                n_state = BK_WJ_RD;
            end
            BK_FS_RD: begin
                if (r_pos >= r_count) begin
                    n_rp = r_pos;
                    n_out_valid = 1'b1;
                    n_out = '0;
                    n_out.overflow = r_dropped;
                    n_state = BK_IDLE;
                end else begin
                    rd_en = 1'b1;
                    n_state = BK_FS_EV;
                end
            end
            BK_FS_EV: begin
                n_pos = r_pos + 1'b1;
                if (r_rdata.supp) begin
                    n_state = BK_FS_RD;
                end else begin
                    n_key = r_rdata;
                    n_rp = r_pos + 1'b1;
                    n_state = BK_FM_RD;
                end
            end
            BK_FM_RD: begin
                if (r_pos >= r_count) begin
                    n_out_valid = 1'b1;
                    n_out = '{found: 1'b1, pix_x: r_key.x, pix_y: r_key.y,
                              key_score: r_key.score, final_key: 1'b1,
                              overflow: r_dropped};
                    n_state = BK_IDLE;
                end else begin
                    rd_en = 1'b1;
                    n_state = BK_FM_EV;
                end
            end
            BK_FM_EV: begin
                if (!r_rdata.supp) begin
                    n_out_valid = 1'b1;
                    n_out = '{found: 1'b1, pix_x: r_key.x, pix_y: r_key.y,
                              key_score: r_key.score, final_key: 1'b0,
                              overflow: r_dropped};
                    n_state = BK_IDLE;
                end else begin
                    n_pos = r_pos + 1'b1;
                    n_state = BK_FM_RD;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_phase <= PH_LOAD;
            r_count <= '0;
            r_rp <= '0;
            r_dropped <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_count <= n_count;
            r_rp <= n_rp;
            r_dropped <= n_dropped;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_j <= n_j;
        r_cmd <= n_cmd;
        r_key <= n_key;
        r_rx <= n_rx;
        r_ry <= n_ry;
        r_out <= n_out;
    end

endmodule

// File: hw/rtl/greedy_keypoint_nms.sv
// Top level of the greedy keypoint suppression block: configuration registers and the
// front and back parts. Depends on gkn_pkg, gkn_front and gkn_back.
//
// Requests enter as a queue: push with full low. A load request carries one score; a
// fetch request asks for the next kept keypoint and yields one result, read while
// empty is low and taken with pop. Load requests yield no result.
// A two-entry command queue sits between the front and the back. A candidate load is
// inserted in score order: each stored candidate with a lower score moves one memory
// entry up. The load marked last then runs the suppression walk, which for each kept
// candidate reads every later candidate through the single memory read port. A fetch
// reads the store entries one by one, up to the next kept entry after the one returned.
// Reset clears the phase, counts and flags and loads threshold 1 and radius_sq 16; the
// store needs no clearing. While pop stays low the finished result waits in the result
// register; queued loads ahead of the next fetch are still processed, but that fetch
// waits at the queue head and holds back every request behind it until pop.
module greedy_keypoint_nms #(
    parameter int MAX_CANDIDATES = gkn_pkg::DefMaxCandidates
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  gkn_pkg::t_in_item              i_in,
    output logic                           empty,
    input  logic                           pop,
    output gkn_pkg::t_out_item             o_out,
    input  logic                           i_cfg_we,
    input  logic [0:0]                     i_cfg_idx,
    input  logic [gkn_pkg::CfgDataW-1:0]   i_cfg_data
);
    import gkn_pkg::*;

    logic signed [15:0] r_threshold;
    logic [21:0] r_radius_sq;
    logic q_valid, q_pop;
    t_cmd q_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= 16'sd1;
            r_radius_sq <= 22'd16;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CfgThreshold) begin
                r_threshold <= i_cfg_data[15:0];
            end else if (i_cfg_idx == CfgRadiusSq) begin
                r_radius_sq <= i_cfg_data[21:0];
            end
        end
    end

    gkn_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in        (i_in),
        .i_threshold (r_threshold),
        .o_q_valid   (q_valid),
        .o_q_head    (q_head),
        .i_q_pop     (q_pop)
    );

    gkn_back #(
        .MAX_CANDIDATES (MAX_CANDIDATES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_head    (q_head),
        .o_q_pop     (q_pop),
        .i_radius_sq (r_radius_sq),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out)
    );

endmodule
